>>> hdl/gjsp_pkg.sv
// Shared types and constants of the grid jump shortest path block.
package gjsp_pkg;

  localparam int CFG_W    = 7;   // width of every configuration register
  localparam int CFG_IW   = 3;   // width of the register index
  localparam int RESULT_W = 13;  // width of move_count

  localparam int MAX_ROWS_DEF = 64;  // default number of rows the memories hold
  localparam int MAX_COLS_DEF = 64;  // default number of columns the memories hold

  typedef enum logic [CFG_IW-1:0] {
    REG_GRID_HEIGHT = 3'd0,
    REG_GRID_WIDTH  = 3'd1,
    REG_JUMP_LIMIT  = 3'd2,
    REG_START_ROW   = 3'd3,
    REG_START_COL   = 3'd4,
    REG_GOAL_ROW    = 3'd5,
    REG_GOAL_COL    = 3'd6
  } cfg_reg_e;

  // Effective search geometry: sizes clamped, start and goal zero-based.
  typedef struct packed {
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] jump;
    logic [CFG_W-1:0] start_row;
    logic [CFG_W-1:0] start_col;
    logic [CFG_W-1:0] goal_row;
    logic [CFG_W-1:0] goal_col;
    logic             off_grid;
  } geom_t;

endpackage

>>> hdl/gjsp_cfg.sv
// Configuration registers and derived search geometry.
module gjsp_cfg import gjsp_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output geom_t             geom_o
);

  logic [CFG_W-1:0] height_q, width_q, jump_q, srow_q, scol_q, grow_q, gcol_q;
  logic [CFG_W-1:0] h_eff, w_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= CFG_W'(1);
      width_q  <= CFG_W'(1);
      jump_q   <= CFG_W'(1);
      srow_q   <= CFG_W'(1);
      scol_q   <= CFG_W'(1);
      grow_q   <= CFG_W'(1);
      gcol_q   <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_HEIGHT: height_q <= cfg_data_i;
        REG_GRID_WIDTH:  width_q  <= cfg_data_i;
        REG_JUMP_LIMIT:  jump_q   <= cfg_data_i;
        REG_START_ROW:   srow_q   <= cfg_data_i;
        REG_START_COL:   scol_q   <= cfg_data_i;
        REG_GOAL_ROW:    grow_q   <= cfg_data_i;
        REG_GOAL_COL:    gcol_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_q == '0) h_eff = CFG_W'(1);
    else if (int'(height_q) > MAX_ROWS) h_eff = CFG_W'(MAX_ROWS);
    else h_eff = height_q;
    if (width_q == '0) w_eff = CFG_W'(1);
    else if (int'(width_q) > MAX_COLS) w_eff = CFG_W'(MAX_COLS);
    else w_eff = width_q;
    geom_o.height    = h_eff;
    geom_o.width     = w_eff;
    geom_o.jump      = (jump_q == '0) ? CFG_W'(1) : jump_q;
    geom_o.start_row = srow_q - CFG_W'(1);
    geom_o.start_col = scol_q - CFG_W'(1);
    geom_o.goal_row  = grow_q - CFG_W'(1);
    geom_o.goal_col  = gcol_q - CFG_W'(1);
    geom_o.off_grid  = (srow_q == '0) || (srow_q > h_eff) || (scol_q == '0) ||
                       (scol_q > w_eff) || (grow_q == '0) || (grow_q > h_eff) ||
                       (gcol_q == '0) || (gcol_q > w_eff);
  end

endmodule

>>> hdl/grid_jump_shortest_path.sv
// Top level of the grid jump shortest path block.
// Grid cells stream in one word per cycle while the block is idle, in row-major
// order, bit 0 of the data being the wall flag, and are written to an on-chip
// wall map. The word that carries tlast starts a breadth-first search from the
// start cell, in which one move travels up to jump_limit cells in a straight line.
// While the search runs the input is not ready. A search first sweeps the distance
// map to unreached, one entry a cycle, and then seeds the queue with the start
// cell. It passes every cell taken from the queue through the POP and CUR states
// and every cell probed along a jump through PROBE and CHECK; a jump that ends at
// the grid edge or at the jump limit is closed in PROBE. The distance memory is
// read for each probe and written for each newly reached cell. Once the queue is
// found empty, GOAL_RD and GOAL read the goal and RESULT hands over the answer,
// which is -1 when the goal cannot be reached or when the start or goal lies
// outside the grid (no search is run then, and the last word leads straight to
// RESULT). An answer still waiting on the output holds the block until it is taken.
// Configuration must be written only while the block is idle (not enforced).
module grid_jump_shortest_path import gjsp_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // Cell stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [0] is_wall, [7:1] zero
  input  logic              s_axis_tlast,   // last_cell
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata    // [12:0] move_count, [15:13] zero
);

  localparam int CAPACITY = MAX_ROWS * MAX_COLS;
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW  = RIW + CIW + CFG_W + 1;
  localparam int DW  = AW + 1;               // distance width, all ones is unreached
  localparam int QW  = RIW + CIW + DW;       // queue word: distance, row, column

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_CLEAR   = 10'b0000000010,
    ST_INIT    = 10'b0000000100,
    ST_POP     = 10'b0000001000,
    ST_CUR     = 10'b0000010000,
    ST_PROBE   = 10'b0000100000,
    ST_CHECK   = 10'b0001000000,
    ST_GOAL_RD = 10'b0010000000,
    ST_GOAL    = 10'b0100000000,
    ST_RESULT  = 10'b1000000000
  } state_e;

  localparam logic [DW-1:0] UNREACHED = '1;

  geom_t geom;

  gjsp_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .geom_o (geom)
  );

  // Memories.
  logic          wall_mem  [CAPACITY];
  logic [DW-1:0] dist_mem  [CAPACITY];
  logic [QW-1:0] queue_mem [CAPACITY];

  state_e state_q, state_d;
  logic [AW-1:0]  load_q, load_d, clr_q, clr_d;
  logic [AW:0]    head_q, head_d, tail_q, tail_d;
  logic [RIW-1:0] cur_r_q, cur_r_d, pr_q, pr_d, cr_q, cr_d;
  logic [CIW-1:0] cur_c_q, cur_c_d, pc_q, pc_d, cc_q, cc_d;
  logic [DW-1:0]  next_q, next_d;
  logic [1:0]     dir_q, dir_d;
  logic [CFG_W:0] step_q, step_d;
  logic [RESULT_W-1:0] res_q, res_d, out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [DW-1:0] dist_rd_q;
  logic          wall_rd_q;
  logic [QW-1:0] queue_rd_q;

  logic          dist_we, wall_we, queue_we;
  logic [AW-1:0] dist_waddr, rd_addr;
  logic [DW-1:0] dist_wdata;
  logic [QW-1:0] queue_wdata;
  logic [AW-1:0] queue_waddr;

  logic [RIW-1:0] start_r, goal_r, cand_r;
  logic [CIW-1:0] start_c, goal_c, cand_c;
  logic [AW-1:0]  start_idx, goal_idx, cand_idx;
  logic           ray_out, accept;
  logic [DW+RESULT_W-1:0] dist_ext;

  function automatic logic [AW-1:0] lin_idx(logic [RIW-1:0] r, logic [CIW-1:0] c,
                                            logic [CFG_W-1:0] w);
    logic [LW-1:0] lin;
    lin = LW'(r) * LW'(w) + LW'(c);
    return lin[AW-1:0];
  endfunction

  assign start_r   = RIW'(geom.start_row);
  assign start_c   = CIW'(geom.start_col);
  assign goal_r    = RIW'(geom.goal_row);
  assign goal_c    = CIW'(geom.goal_col);
  assign start_idx = lin_idx(start_r, start_c, geom.width);
  assign goal_idx  = lin_idx(goal_r, goal_c, geom.width);
  assign cand_idx  = lin_idx(cand_r, cand_c, geom.width);
  assign dist_ext  = (DW+RESULT_W)'(dist_rd_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

  // Next cell along the current ray, and whether the ray has ended.
  always_comb begin
    cand_r  = pr_q;
    cand_c  = pc_q;
    ray_out = 1'b0;
    case (dir_q)
      2'd0: begin
        cand_c  = pc_q + CIW'(1);
        ray_out = (int'(pc_q) + 1 >= int'(geom.width));
      end
      2'd1: begin
        cand_c  = pc_q - CIW'(1);
        ray_out = (pc_q == '0);
      end
      2'd2: begin
        cand_r  = pr_q - RIW'(1);
        ray_out = (pr_q == '0);
      end
      default: begin
        cand_r  = pr_q + RIW'(1);
        ray_out = (int'(pr_q) + 1 >= int'(geom.height));
      end
    endcase
    if (step_q > (CFG_W+1)'(geom.jump)) ray_out = 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    load_d      = load_q;
    clr_d       = clr_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_r_d     = cur_r_q;
    cur_c_d     = cur_c_q;
    pr_d        = pr_q;
    pc_d        = pc_q;
    cr_d        = cr_q;
    cc_d        = cc_q;
    next_d      = next_q;
    dir_d       = dir_q;
    step_d      = step_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    wall_we     = 1'b0;
    dist_we     = 1'b0;
    queue_we    = 1'b0;
    dist_waddr  = clr_q;
    dist_wdata  = UNREACHED;
    queue_waddr = tail_q[AW-1:0];
    queue_wdata = {next_q, cr_q, cc_q};
    rd_addr     = cand_idx;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wall_we = 1'b1;
          load_d  = (load_q == AW'(CAPACITY - 1)) ? '0 : load_q + AW'(1);
          if (s_axis_tlast) begin
            load_d = '0;
            clr_d  = '0;
            if (geom.off_grid) begin
              res_d   = '1;
              state_d = ST_RESULT;
            end else begin
              state_d = ST_CLEAR;
            end
          end
        end
      end
      ST_CLEAR: begin
        dist_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == AW'(CAPACITY - 1)) state_d = ST_INIT;
      end
      ST_INIT: begin
        dist_we     = 1'b1;
        dist_waddr  = start_idx;
        dist_wdata  = '0;
        queue_we    = 1'b1;
        queue_waddr = '0;
        queue_wdata = {{DW{1'b0}}, start_r, start_c};
        head_d      = '0;
        tail_d      = (AW+1)'(1);
        state_d     = ST_POP;
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          state_d = ST_GOAL_RD;
        end else begin
          head_d  = head_q + (AW+1)'(1);
          state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        next_d  = queue_rd_q[QW-1 -: DW] + DW'(1);
        cur_r_d = queue_rd_q[CIW +: RIW];
        cur_c_d = queue_rd_q[CIW-1:0];
        pr_d    = queue_rd_q[CIW +: RIW];
        pc_d    = queue_rd_q[CIW-1:0];
        dir_d   = 2'd0;
        step_d  = (CFG_W+1)'(1);
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (ray_out) begin
          pr_d   = cur_r_q;
          pc_d   = cur_c_q;
          step_d = (CFG_W+1)'(1);
          dir_d  = dir_q + 2'd1;
          if (dir_q == 2'd3) state_d = ST_POP;
        end else begin
          cr_d    = cand_r;
          cc_d    = cand_c;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_PROBE;
        if ((dist_rd_q != UNREACHED && dist_rd_q != next_q) ||
            (dist_rd_q == UNREACHED && wall_rd_q)) begin
          // Blocked: the ray ends here.
          pr_d   = cur_r_q;
          pc_d   = cur_c_q;
          step_d = (CFG_W+1)'(1);
          dir_d  = dir_q + 2'd1;
          if (dir_q == 2'd3) state_d = ST_POP;
        end else begin
          if (dist_rd_q == UNREACHED) begin
            dist_we    = 1'b1;
            dist_waddr = lin_idx(cr_q, cc_q, geom.width);
            dist_wdata = next_q;
            queue_we   = 1'b1;
            tail_d     = tail_q + (AW+1)'(1);
          end
          pr_d   = cr_q;
          pc_d   = cc_q;
          step_d = step_q + (CFG_W+1)'(1);
        end
      end
      ST_GOAL_RD: begin
        rd_addr = goal_idx;
        state_d = ST_GOAL;
      end
      ST_GOAL: begin
        res_d   = (dist_rd_q == UNREACHED) ? '1 : dist_ext[RESULT_W-1:0];
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_q      <= '0;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_q      <= load_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q <= cur_r_d;
    cur_c_q <= cur_c_d;
    pr_q    <= pr_d;
    pc_q    <= pc_d;
    cr_q    <= cr_d;
    cc_q    <= cc_d;
    next_q  <= next_d;
    dir_q   <= dir_d;
    step_q  <= step_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[load_q] <= s_axis_tdata[0];
    wall_rd_q <= wall_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) dist_mem[dist_waddr] <= dist_wdata;
    dist_rd_q <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_waddr] <= queue_wdata;
    queue_rd_q <= queue_mem[head_q[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head has overtaken the tail");

  a_check_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> $past(state_q) == ST_PROBE)
    else $error("distance check without a preceding probe read");

  a_write_unreached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && dist_we) |-> dist_rd_q == UNREACHED)
    else $error("a reached cell was overwritten");
`endif

endmodule
